FILE: src/crpf_pkg.sv
package crpf_pkg;

    // Table depth and the widths that follow from it.
    localparam int CIRCLES     = 64;
    localparam int ADDR_W      = (CIRCLES > 1) ? $clog2(CIRCLES) : 1;
    localparam int CNT_W       = $clog2(CIRCLES + 1);

    // Fixed field widths.
    localparam int COUNT_REG_W = 7;
    localparam int MARGIN_W    = 12;
    localparam int COORD_W     = 24;
    localparam int RADIUS_W    = 16;
    localparam int SLOT_W      = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int CMP_W       = (CNT_W > COUNT_REG_W) ? CNT_W : COUNT_REG_W;

    // Distance datapath widths.
    localparam int DIFF_W      = COORD_W + 1;
    localparam int AXIS_LIMIT  = 1 << 20;
    localparam int ABS_W       = 21;
    localparam int SQ_W        = 2 * ABS_W - 1;
    localparam int D2_W        = SQ_W + 2;
    localparam int BOUND_W     = RADIUS_W + 1;
    localparam int BOUND2_W    = 2 * BOUND_W;

    // Per-axis limits at the width of an axis difference.
    localparam logic signed [DIFF_W-1:0] LIMIT_P = DIFF_W'(AXIS_LIMIT);
    localparam logic signed [DIFF_W-1:0] LIMIT_N = DIFF_W'(-AXIS_LIMIT);

    // Command queue between the front and the back.
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT = 2'd0,
        CFG_INNER = 2'd1,
        CFG_OUTER = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_POINT = 1'b1
    } t_kind;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [RADIUS_W-1:0]       radius;
    } t_circle;

    typedef struct packed {
        t_kind             kind;
        logic              wr_ok;
        logic [ADDR_W-1:0] addr;
        t_circle           data;
        logic [CNT_W-1:0]  count;
    } t_cmd;

    typedef struct packed {
        logic [MARGIN_W-1:0] inner;
        logic [MARGIN_W-1:0] outer;
    } t_ring_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [SLOT_W-1:0] s);
        logic [31:0] w;
        w = 32'(s);
        return w[ADDR_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] to_slot(input logic [ADDR_W-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[SLOT_W-1:0];
    endfunction

endpackage

FILE: src/crpf_front.sv
module crpf_front (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic                                    i_kind,
    input  logic [crpf_pkg::SLOT_W-1:0]             i_slot,
    input  logic signed [crpf_pkg::COORD_W-1:0]     i_pos_x,
    input  logic signed [crpf_pkg::COORD_W-1:0]     i_pos_y,
    input  logic signed [crpf_pkg::COORD_W-1:0]     i_pos_z,
    input  logic [crpf_pkg::RADIUS_W-1:0]           i_radius,
    input  logic [crpf_pkg::COUNT_REG_W-1:0]        i_count,
    input  logic                                    i_fifo_full,
    output logic                                    o_busy,
    output logic                                    o_push,
    output crpf_pkg::t_cmd                          o_cmd
);

    logic           r_vld;
    crpf_pkg::t_cmd r_cmd;
    crpf_pkg::t_cmd n_cmd;
    logic           w_accept;

    // Classify the item: decode its kind, range-check the slot and clamp the count.
    always_comb begin
        n_cmd.kind        = crpf_pkg::t_kind'(i_kind);
        n_cmd.wr_ok       = (32'(i_slot) < 32'(crpf_pkg::CIRCLES));
        n_cmd.addr        = crpf_pkg::to_addr(i_slot);
        n_cmd.data.x      = i_pos_x;
        n_cmd.data.y      = i_pos_y;
        n_cmd.data.z      = i_pos_z;
        n_cmd.data.radius = i_radius;
        if (crpf_pkg::CMP_W'(i_count) > crpf_pkg::CMP_W'(crpf_pkg::CIRCLES)) begin
            n_cmd.count = crpf_pkg::CNT_W'(crpf_pkg::CIRCLES);
        end else begin
            n_cmd.count = crpf_pkg::CNT_W'(i_count);
        end
    end

    assign o_push   = r_vld && !i_fifo_full;
    assign o_busy   = r_vld && i_fifo_full;
    assign w_accept = i_start && !o_busy;
    assign o_cmd    = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: src/crpf_fifo.sv
module crpf_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  crpf_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output crpf_pkg::t_cmd       o_head,
    output crpf_pkg::t_fifo_stat o_stat
);

    crpf_pkg::t_cmd                   r_mem [crpf_pkg::FIFO_DEPTH];
    logic [crpf_pkg::FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [crpf_pkg::FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [crpf_pkg::FIFO_CNT_W-1:0]  r_cnt;

    assign o_stat.full  = (r_cnt == crpf_pkg::FIFO_CNT_W'(crpf_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + crpf_pkg::FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + crpf_pkg::FIFO_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + crpf_pkg::FIFO_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - crpf_pkg::FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: src/crpf_back.sv
module crpf_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  crpf_pkg::t_ring_cfg            i_cfg,
    input  crpf_pkg::t_cmd                 i_head,
    input  logic                           i_empty,
    output logic                           o_pop,
    output logic                           o_idle,
    output logic                           o_result_valid,
    output logic                           o_keep_point,
    output logic [crpf_pkg::SLOT_W-1:0]    o_hit_slot
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    t_state                              r_state;
    logic [crpf_pkg::CNT_W-1:0]          r_left;
    logic [crpf_pkg::ADDR_W-1:0]         r_issue;
    logic                                r_out_vld;
    logic                                r_keep;
    logic [crpf_pkg::SLOT_W-1:0]         r_hit;

    // Circle table.
    crpf_pkg::t_circle                   r_mem [crpf_pkg::CIRCLES];
    crpf_pkg::t_circle                   r_pt;

    // Stage A: registered table read.
    logic                                r_a_vld;
    logic                                r_a_last;
    logic [crpf_pkg::ADDR_W-1:0]         r_a_idx;
    crpf_pkg::t_circle                   r_rd;

    // Stage B: axis differences and ring bounds.
    logic                                r_b_vld;
    logic                                r_b_last;
    logic [crpf_pkg::ADDR_W-1:0]         r_b_idx;
    logic                                r_b_far;
    logic [crpf_pkg::ABS_W-1:0]          r_b_ax;
    logic [crpf_pkg::ABS_W-1:0]          r_b_ay;
    logic [crpf_pkg::ABS_W-1:0]          r_b_az;
    logic [crpf_pkg::BOUND_W-1:0]        r_b_lo;
    logic [crpf_pkg::BOUND_W-1:0]        r_b_hi;

    // Stage C: squares.
    logic                                r_c_vld;
    logic                                r_c_last;
    logic [crpf_pkg::ADDR_W-1:0]         r_c_idx;
    logic                                r_c_far;
    logic [crpf_pkg::SQ_W-1:0]           r_c_sx;
    logic [crpf_pkg::SQ_W-1:0]           r_c_sy;
    logic [crpf_pkg::SQ_W-1:0]           r_c_sz;
    logic [crpf_pkg::BOUND2_W-1:0]       r_c_lo2;
    logic [crpf_pkg::BOUND2_W-1:0]       r_c_hi2;

    // Stage D: squared distance.
    logic                                r_d_vld;
    logic                                r_d_last;
    logic [crpf_pkg::ADDR_W-1:0]         r_d_idx;
    logic                                r_d_far;
    logic [crpf_pkg::D2_W-1:0]           r_d_d2;
    logic [crpf_pkg::BOUND2_W-1:0]       r_d_lo2;
    logic [crpf_pkg::BOUND2_W-1:0]       r_d_hi2;

    logic                                w_issue;
    logic                                w_hit;
    logic                                w_finish;
    logic signed [crpf_pkg::DIFF_W-1:0]  w_dx;
    logic signed [crpf_pkg::DIFF_W-1:0]  w_dy;
    logic signed [crpf_pkg::DIFF_W-1:0]  w_dz;
    logic                                w_far;

    assign o_idle         = (r_state == ST_IDLE);
    assign o_pop          = o_idle && !i_empty;
    assign o_result_valid = r_out_vld;
    assign o_keep_point   = r_keep;
    assign o_hit_slot     = r_hit;

    // The last stage decides; results arrive in table order, so the first hit wins.
    assign w_hit    = r_d_vld && !r_d_far &&
                      (r_d_d2 > crpf_pkg::D2_W'(r_d_lo2)) &&
                      (r_d_d2 < crpf_pkg::D2_W'(r_d_hi2));
    assign w_finish = r_d_vld && (w_hit || r_d_last);
    assign w_issue  = (r_state == ST_WALK) && (r_left != '0) && !w_finish;

    always_comb begin
        w_dx  = crpf_pkg::DIFF_W'(r_pt.x) - crpf_pkg::DIFF_W'(r_rd.x);
        w_dy  = crpf_pkg::DIFF_W'(r_pt.y) - crpf_pkg::DIFF_W'(r_rd.y);
        w_dz  = crpf_pkg::DIFF_W'(r_pt.z) - crpf_pkg::DIFF_W'(r_rd.z);
        w_far = (w_dx > crpf_pkg::LIMIT_P) || (w_dx < crpf_pkg::LIMIT_N) ||
                (w_dy > crpf_pkg::LIMIT_P) || (w_dy < crpf_pkg::LIMIT_N) ||
                (w_dz > crpf_pkg::LIMIT_P) || (w_dz < crpf_pkg::LIMIT_N);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_left    <= '0;
            r_issue   <= '0;
            r_out_vld <= 1'b0;
            r_keep    <= 1'b0;
            r_hit     <= '0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (o_pop && (i_head.kind == crpf_pkg::KIND_POINT)) begin
                        if (i_head.count == '0) begin
                            r_out_vld <= 1'b1;
                            r_keep    <= 1'b1;
                            r_hit     <= '0;
                        end else begin
                            r_state <= ST_WALK;
                            r_left  <= i_head.count;
                            r_issue <= '0;
                        end
                    end
                end
                ST_WALK: begin
                    if (w_issue) begin
                        r_issue <= r_issue + crpf_pkg::ADDR_W'(1);
                        r_left  <= r_left - crpf_pkg::CNT_W'(1);
                    end
                    if (w_finish) begin
                        r_state   <= ST_IDLE;
                        r_out_vld <= 1'b1;
                        r_keep    <= !w_hit;
                        r_hit     <= w_hit ? crpf_pkg::to_slot(r_d_idx) : '0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // A finished walk flushes whatever is still in flight.
            r_a_vld <= w_issue;
            r_b_vld <= r_a_vld && !w_finish;
            r_c_vld <= r_b_vld && !w_finish;
            r_d_vld <= r_c_vld && !w_finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.kind == crpf_pkg::KIND_LOAD) && i_head.wr_ok) begin
            r_mem[i_head.addr] <= i_head.data;
        end
        if (o_pop && (i_head.kind == crpf_pkg::KIND_POINT)) begin
            r_pt <= i_head.data;
        end
        if (w_issue) begin
            r_rd     <= r_mem[r_issue];
            r_a_idx  <= r_issue;
            r_a_last <= (r_left == crpf_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_last <= r_a_last;
        r_b_idx  <= r_a_idx;
        r_b_far  <= w_far;
        r_b_ax   <= crpf_pkg::ABS_W'(w_dx[crpf_pkg::DIFF_W-1] ? -w_dx : w_dx);
        r_b_ay   <= crpf_pkg::ABS_W'(w_dy[crpf_pkg::DIFF_W-1] ? -w_dy : w_dy);
        r_b_az   <= crpf_pkg::ABS_W'(w_dz[crpf_pkg::DIFF_W-1] ? -w_dz : w_dz);
        r_b_lo   <= crpf_pkg::BOUND_W'(r_rd.radius) + crpf_pkg::BOUND_W'(i_cfg.inner);
        r_b_hi   <= crpf_pkg::BOUND_W'(r_rd.radius) + crpf_pkg::BOUND_W'(i_cfg.outer);

        r_c_last <= r_b_last;
        r_c_idx  <= r_b_idx;
        r_c_far  <= r_b_far;
        r_c_sx   <= crpf_pkg::SQ_W'(r_b_ax) * crpf_pkg::SQ_W'(r_b_ax);
        r_c_sy   <= crpf_pkg::SQ_W'(r_b_ay) * crpf_pkg::SQ_W'(r_b_ay);
        r_c_sz   <= crpf_pkg::SQ_W'(r_b_az) * crpf_pkg::SQ_W'(r_b_az);
        r_c_lo2  <= crpf_pkg::BOUND2_W'(r_b_lo) * crpf_pkg::BOUND2_W'(r_b_lo);
        r_c_hi2  <= crpf_pkg::BOUND2_W'(r_b_hi) * crpf_pkg::BOUND2_W'(r_b_hi);

        r_d_last <= r_c_last;
        r_d_idx  <= r_c_idx;
        r_d_far  <= r_c_far;
        r_d_d2   <= crpf_pkg::D2_W'(r_c_sx) + crpf_pkg::D2_W'(r_c_sy) +
                    crpf_pkg::D2_W'(r_c_sz);
        r_d_lo2  <= r_c_lo2;
        r_d_hi2  <= r_c_hi2;
    end

endmodule

FILE: src/circle_ring_point_filter_top.sv
// Circle ring point filter.
//
// Commands enter on start/busy: a command transfers at a rising edge where start is
// high and busy is low. A load command (kind 0) writes the circle table entry at slot;
// a point command (kind 1) tests the point against the first circle_count entries and
// yields one result, shown for exactly one cycle with o_result_valid. The receiver
// cannot stall, so a result is never held. Load commands yield no result.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user writes it
// only while the block is idle, which the block itself does not enforce.
// A front stage classifies each command and pushes it into a two-entry queue; the
// back end drains the queue. The back end takes a load or a point with a count of
// zero straight from idle; any other point walks the table through the single
// distance pipeline, which reads one table entry per cycle, until the last entry
// or the first ring that catches the point. Reset clears the configuration to
// count 0, margins 20 and 200 mm, and empties the queue; the table contents are
// not cleared.
module circle_ring_point_filter_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    i_kind,
    input  logic [crpf_pkg::SLOT_W-1:0]             i_slot,
    input  logic signed [crpf_pkg::COORD_W-1:0]     i_pos_x,
    input  logic signed [crpf_pkg::COORD_W-1:0]     i_pos_y,
    input  logic signed [crpf_pkg::COORD_W-1:0]     i_pos_z,
    input  logic [crpf_pkg::RADIUS_W-1:0]           i_radius,
    input  logic                                    i_cfg_we,
    input  logic [crpf_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [crpf_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    output logic                                    o_result_valid,
    output logic                                    o_keep_point,
    output logic [crpf_pkg::SLOT_W-1:0]             o_hit_slot
);

    logic [crpf_pkg::COUNT_REG_W-1:0] r_count;
    logic [crpf_pkg::MARGIN_W-1:0]    r_inner;
    logic [crpf_pkg::MARGIN_W-1:0]    r_outer;
    crpf_pkg::t_ring_cfg              w_ring_cfg;

    logic                             w_push;
    logic                             w_pop;
    logic                             w_back_idle;
    crpf_pkg::t_cmd                   w_front_cmd;
    crpf_pkg::t_cmd                   w_head;
    crpf_pkg::t_fifo_stat             w_fifo_stat;

    // Configuration registers. A write to an index past the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= crpf_pkg::COUNT_REG_W'(0);
            r_inner <= crpf_pkg::MARGIN_W'(20);
            r_outer <= crpf_pkg::MARGIN_W'(200);
        end else if (i_cfg_we) begin
            case (crpf_pkg::t_cfg_idx'(i_cfg_idx))
                crpf_pkg::CFG_COUNT: begin
                    r_count <= i_cfg_data[crpf_pkg::COUNT_REG_W-1:0];
                end
                crpf_pkg::CFG_INNER: begin
                    r_inner <= i_cfg_data;
                end
                crpf_pkg::CFG_OUTER: begin
                    r_outer <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_ring_cfg.inner = r_inner;
    assign w_ring_cfg.outer = r_outer;

    // The front end holds one classified command until the queue has room.
    crpf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_kind      (i_kind),
        .i_slot      (i_slot),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_radius    (i_radius),
        .i_count     (r_count),
        .i_fifo_full (w_fifo_stat.full),
        .o_busy      (busy),
        .o_push      (w_push),
        .o_cmd       (w_front_cmd)
    );

    crpf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_fifo_stat)
    );

    // The back end owns the circle table and the distance pipeline.
    crpf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_ring_cfg),
        .i_head         (w_head),
        .i_empty        (w_fifo_stat.empty),
        .o_pop          (w_pop),
        .o_idle         (w_back_idle),
        .o_result_valid (o_result_valid),
        .o_keep_point   (o_keep_point),
        .o_hit_slot     (o_hit_slot)
    );

    // A kept point never reports a slot.
    a_keep_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_keep_point) |-> (o_hit_slot == '0))
        else $error("kept point reports a nonzero slot");

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_fifo_stat.full)
        else $error("push into a full command queue");

    // A result is only shown once the back end has finished its walk.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> w_back_idle)
        else $error("result shown while the back end is still walking");

    // With nothing queued and no walk running, no result can appear next cycle.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_back_idle && w_fifo_stat.empty) |=> !o_result_valid)
        else $error("result without a queued point");

endmodule

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // The watchdog ends the run after this many cycles without any transfer,
    // result or register write. The slowest legal stretch is a long sender gap
    // or one full 64-circle scan inside the block.
    localparam int STALL_LIMIT   = 4000;
    // Cycles allowed for load commands still inside the block's queue to retire
    // once the last expected verdict has arrived.
    localparam int SETTLE_CYCLES = 12;

    // One command as it sits in the pending queue.
    typedef struct {
        crpf_pkg::t_kind                     kind;
        logic [crpf_pkg::SLOT_W-1:0]         slot;
        logic signed [crpf_pkg::COORD_W-1:0] x;
        logic signed [crpf_pkg::COORD_W-1:0] y;
        logic signed [crpf_pkg::COORD_W-1:0] z;
        logic [crpf_pkg::RADIUS_W-1:0]       radius;
    } t_ring_cmd;

    // The verdict that a point command is expected to produce.
    typedef struct {
        logic                        keep;
        logic [crpf_pkg::SLOT_W-1:0] slot;
    } t_ring_verdict;

    logic                                i_clk;
    logic                                i_rst_n    = 1'b0;
    logic                                start      = 1'b0;
    logic                                busy;
    logic                                i_kind     = 1'b0;
    logic [crpf_pkg::SLOT_W-1:0]         i_slot     = '0;
    logic signed [crpf_pkg::COORD_W-1:0] i_pos_x    = '0;
    logic signed [crpf_pkg::COORD_W-1:0] i_pos_y    = '0;
    logic signed [crpf_pkg::COORD_W-1:0] i_pos_z    = '0;
    logic [crpf_pkg::RADIUS_W-1:0]       i_radius   = '0;
    logic                                i_cfg_we   = 1'b0;
    logic [crpf_pkg::CFG_IDX_W-1:0]      i_cfg_idx  = '0;
    logic [crpf_pkg::CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                                o_result_valid;
    logic                                o_keep_point;
    logic [crpf_pkg::SLOT_W-1:0]         o_hit_slot;

    circle_ring_point_filter_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_slot         (i_slot),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_radius       (i_radius),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_keep_point   (o_keep_point),
        .o_hit_slot     (o_hit_slot)
    );

    // 50 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the circle table and the ring
    // registers. The table is updated in transfer order, so it always
    // matches what the block holds when a point command reaches it.
    // ------------------------------------------------------------------
    logic signed [crpf_pkg::COORD_W-1:0] ring_cx  [crpf_pkg::CIRCLES];
    logic signed [crpf_pkg::COORD_W-1:0] ring_cy  [crpf_pkg::CIRCLES];
    logic signed [crpf_pkg::COORD_W-1:0] ring_cz  [crpf_pkg::CIRCLES];
    logic [crpf_pkg::RADIUS_W-1:0]       ring_rad [crpf_pkg::CIRCLES];
    logic [crpf_pkg::COUNT_REG_W-1:0]    ring_count = 7'd0;
    logic [crpf_pkg::MARGIN_W-1:0]       ring_inner = 12'd20;
    logic [crpf_pkg::MARGIN_W-1:0]       ring_outer = 12'd200;

    // The stimulus generator runs ahead of the block, so it aims points at
    // its own view of the table, which already includes queued loads.
    int plan_cx  [crpf_pkg::CIRCLES];
    int plan_cy  [crpf_pkg::CIRCLES];
    int plan_cz  [crpf_pkg::CIRCLES];
    int plan_rad [crpf_pkg::CIRCLES];

    t_ring_cmd     cmd_q[$];        // commands waiting for the driver
    t_ring_verdict verdict_q[$];    // verdicts waiting for the block's results

    t_ring_cmd cur_cmd;             // command currently offered on the ports
    int        gap_left    = 0;     // idle cycles before the next command
    bit        no_gaps     = 1'b0;  // set for phases run back to back
    int        err_count   = 0;
    int        n_points    = 0;
    int        n_loads     = 0;
    int        n_kept      = 0;
    int        n_dropped   = 0;
    int        n_settings  = 0;
    int        idle_cycles = 0;

    // True when the point lies strictly inside circle j's exclusion ring.
    // Squared distances are compared against squared bounds; any axis more
    // than the axis limit away rules the circle out before squaring.
    function automatic bit in_exclusion_ring(input int j,
                                             input logic signed [crpf_pkg::COORD_W-1:0] px,
                                             input logic signed [crpf_pkg::COORD_W-1:0] py,
                                             input logic signed [crpf_pkg::COORD_W-1:0] pz);
        longint dx, dy, dz, d2, lo, hi;
        dx = longint'(px) - longint'(ring_cx[j]);
        dy = longint'(py) - longint'(ring_cy[j]);
        dz = longint'(pz) - longint'(ring_cz[j]);
        if (dx > crpf_pkg::AXIS_LIMIT || dx < -crpf_pkg::AXIS_LIMIT) return 1'b0;
        if (dy > crpf_pkg::AXIS_LIMIT || dy < -crpf_pkg::AXIS_LIMIT) return 1'b0;
        if (dz > crpf_pkg::AXIS_LIMIT || dz < -crpf_pkg::AXIS_LIMIT) return 1'b0;
        d2 = dx * dx + dy * dy + dz * dz;
        lo = longint'(ring_rad[j]) + longint'(ring_inner);
        hi = longint'(ring_rad[j]) + longint'(ring_outer);
        return (d2 > lo * lo) && (d2 < hi * hi);
    endfunction

    // Applies one transferred command: a load updates the table, a point
    // queues the verdict of the first ring that catches it.
    function automatic void filter_command(input t_ring_cmd c);
        t_ring_verdict v;
        int            n;
        if (c.kind == crpf_pkg::KIND_LOAD) begin
            ring_cx[c.slot]  = c.x;
            ring_cy[c.slot]  = c.y;
            ring_cz[c.slot]  = c.z;
            ring_rad[c.slot] = c.radius;
        end else begin
            // A count above the table depth saturates.
            n = (ring_count > crpf_pkg::CIRCLES) ? crpf_pkg::CIRCLES : int'(ring_count);
            v.keep = 1'b1;
            v.slot = '0;
            for (int j = 0; j < n; j++) begin
                if (in_exclusion_ring(j, c.x, c.y, c.z)) begin
                    v.keep = 1'b0;
                    v.slot = j[crpf_pkg::SLOT_W-1:0];
                    break;
                end
            end
            verdict_q = {verdict_q, v};
        end
    endfunction

    function automatic void push_load(input int slot, input int x, input int y,
                                      input int z, input int radius);
        t_ring_cmd c;
        c.kind   = crpf_pkg::KIND_LOAD;
        c.slot   = slot[crpf_pkg::SLOT_W-1:0];
        c.x      = x[crpf_pkg::COORD_W-1:0];
        c.y      = y[crpf_pkg::COORD_W-1:0];
        c.z      = z[crpf_pkg::COORD_W-1:0];
        c.radius = radius[crpf_pkg::RADIUS_W-1:0];
        plan_cx[c.slot]  = c.x;
        plan_cy[c.slot]  = c.y;
        plan_cz[c.slot]  = c.z;
        plan_rad[c.slot] = c.radius;
        cmd_q = {cmd_q, c};
    endfunction

    // Coordinates wrap to the field width. The slot and radius fields are
    // don't-care for a point, so they carry random bits.
    function automatic void push_point(input int x, input int y, input int z);
        t_ring_cmd c;
        c.kind   = crpf_pkg::KIND_POINT;
        c.slot   = crpf_pkg::SLOT_W'($urandom);
        c.x      = x[crpf_pkg::COORD_W-1:0];
        c.y      = y[crpf_pkg::COORD_W-1:0];
        c.z      = z[crpf_pkg::COORD_W-1:0];
        c.radius = crpf_pkg::RADIUS_W'($urandom);
        cmd_q = {cmd_q, c};
    endfunction

    // Most circles sit in one cluster around the origin so that rings
    // overlap and the first-match order matters; some are spread over the
    // whole coordinate range.
    function automatic void push_circle(input int slot);
        int x, y, z, r;
        if ($urandom_range(0, 4) == 0) begin
            x = $urandom;
            y = $urandom;
            z = $urandom;
        end else begin
            x = int'($urandom_range(0, 6000)) - 3000;
            y = int'($urandom_range(0, 6000)) - 3000;
            z = int'($urandom_range(0, 6000)) - 3000;
        end
        case ($urandom_range(0, 19))
            0, 1, 2: r = $urandom_range(0, 65535);
            3:       r = 65535;
            4:       r = 0;
            default: r = $urandom_range(0, 2500);
        endcase
        push_load(slot, x, y, z, r);
    endfunction

    // A point at a chosen distance from one of the active circles. A quarter
    // of them sit on a ring bound or one millimetre either side of it, along
    // a single axis; the rest spread the distance over all three axes.
    function automatic void push_aimed_point(input int n);
        int     j, lo, hi, d, a, b, c, ox, oy, oz;
        longint rem;
        j  = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, crpf_pkg::CIRCLES - 1);
        lo = plan_rad[j] + int'(ring_inner);
        hi = plan_rad[j] + int'(ring_outer);
        if (lo > hi) begin
            a  = lo;
            lo = hi;
            hi = a;
        end
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
                0:       d = lo - 1;
                1:       d = lo;
                2:       d = lo + 1;
                3:       d = hi - 1;
                4:       d = hi;
                default: d = hi + 1;
            endcase
            if (d < 0) d = 0;
            a = d;
            b = 0;
            c = 0;
        end else begin
            d   = $urandom_range((lo > 2) ? lo - 2 : 0, hi + 2);
            a   = $urandom_range(0, d);
            rem = longint'(d) * d - longint'(a) * a;
            b   = $urandom_range(0, int'($floor($sqrt(real'(rem)))));
            rem = rem - longint'(b) * b;
            c   = int'($floor($sqrt(real'(rem))));
        end
        case ($urandom_range(0, 2))
            0: begin ox = a; oy = b; oz = c; end
            1: begin ox = b; oy = c; oz = a; end
            default: begin ox = c; oy = a; oz = b; end
        endcase
        if ($urandom_range(0, 1)) ox = -ox;
        if ($urandom_range(0, 1)) oy = -oy;
        if ($urandom_range(0, 1)) oz = -oz;
        push_point(plan_cx[j] + ox, plan_cy[j] + oy, plan_cz[j] + oz);
    endfunction

    // A point whose offset from a circle straddles the per-axis limit.
    function automatic void push_far_point(input int n);
        int j, k, ox, oy, oz;
        j  = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, crpf_pkg::CIRCLES - 1);
        k  = crpf_pkg::AXIS_LIMIT - 1 + int'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) k = -k;
        ox = int'($urandom_range(0, 400)) - 200;
        oy = int'($urandom_range(0, 400)) - 200;
        oz = int'($urandom_range(0, 400)) - 200;
        case ($urandom_range(0, 2))
            0:       ox = k;
            1:       oy = k;
            default: oz = k;
        endcase
        push_point(plan_cx[j] + ox, plan_cy[j] + oy, plan_cz[j] + oz);
    endfunction

    // Gap after a command: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        err_count++;
    endtask

    // Waits until every pending command has transferred and every expected
    // verdict has come back, then lets queued loads retire inside the block.
    // Each check runs just after the edge, once the driver's updates for that
    // edge have landed, so a command that has just been offered is seen.
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (cmd_q.size() != 0 || start || busy || verdict_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input crpf_pkg::t_cfg_idx idx, input int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[crpf_pkg::CFG_DATA_W-1:0];
        case (idx)
            crpf_pkg::CFG_COUNT: ring_count = value[crpf_pkg::COUNT_REG_W-1:0];
            crpf_pkg::CFG_INNER: ring_inner = value[crpf_pkg::MARGIN_W-1:0];
            crpf_pkg::CFG_OUTER: ring_outer = value[crpf_pkg::MARGIN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Registers change only with the block drained. This is also where the
    // sender pauses until every expected result has come.
    task automatic set_rings(input int count, input int inner, input int outer);
        wait_idle();
        write_reg(crpf_pkg::CFG_COUNT, count);
        write_reg(crpf_pkg::CFG_INNER, inner);
        write_reg(crpf_pkg::CFG_OUTER, outer);
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the next pending command once the chosen gap has run
    // out, and holds it while busy is high. A transfer happens at an edge
    // where start is high and busy is low; the predictor sees the command
    // at that same edge, so its table follows the block's order exactly.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                filter_command(cur_cmd);
                if (cur_cmd.kind == crpf_pkg::KIND_LOAD) n_loads++;
                else n_points++;
            end
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    cur_cmd   = cmd_q.pop_front();
                    i_kind   <= cur_cmd.kind;
                    i_slot   <= cur_cmd.slot;
                    i_pos_x  <= cur_cmd.x;
                    i_pos_y  <= cur_cmd.y;
                    i_pos_z  <= cur_cmd.z;
                    i_radius <= cur_cmd.radius;
                    start    <= 1'b1;
                    gap_left  = pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: a result is valid for exactly one cycle and transfers at the
    // edge that ends it. Each one is matched against the oldest verdict.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_ring_verdict v;
        if (i_rst_n && o_result_valid) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("result keep=%0b slot=%0d with none expected",
                                          o_keep_point, o_hit_slot));
            end else begin
                v = verdict_q.pop_front();
                if (o_keep_point !== v.keep)
                    report_mismatch($sformatf("keep_point %0b, expected %0b",
                                              o_keep_point, v.keep));
                if (o_hit_slot !== v.slot)
                    report_mismatch($sformatf("hit_slot %0d, expected %0d",
                                              o_hit_slot, v.slot));
                if (v.keep) n_kept++;
                else n_dropped++;
            end
        end
    end

    // Watchdog: any transfer, result or register write restarts the count.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("FAIL circle_ring_point_filter_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: a directed opening, a fill of the whole table, then random
    // phases, each under its own ring settings.
    // ------------------------------------------------------------------
    initial begin
        int n, r, cnt, a, b, items;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With the reset count of zero no circle is consulted, so even the
        // coordinate extremes are kept.
        push_point(-8388608, -8388608, -8388608);
        push_point(8388607, 8388607, 8388607);

        // A few circles at the extremes of every load field. Slot 63 is written here,
        // but the fill of the whole table overwrites it before any count reaches it.
        push_load(0, 0, 0, 0, 1000);
        push_load(1, 0, 0, 0, 0);
        push_load(2, 8388607, -8388608, 8388607, 65535);
        push_load(3, -8388608, 8388607, 0, 500);
        push_load(63, 1, 2, 3, 65535);

        // Reset margins of 20 and 200 mm over the four circles above.
        set_rings(4, 20, 200);
        push_point(1100, 0, 0);                         // inside ring of slot 0
        push_point(100, 0, 0);                          // misses slot 0, caught by slot 1
        push_point(1020, 0, 0);                         // exactly on an inner bound
        push_point(1200, 0, 0);                         // exactly on an outer bound
        push_point(20, 0, 0);                           // inner bound of the zero radius
        push_point(0, 0, 0);                            // at the shared centre
        push_point(8323007, -8388608, 8388607);         // ring of the largest radius
        push_point(-8388608, 8387907, 0);               // exactly on the outer bound of slot 3
        push_point(crpf_pkg::AXIS_LIMIT, 0, 0);         // axis offset at the limit
        push_point(crpf_pkg::AXIS_LIMIT + 1, 0, 0);     // axis offset past the limit

        // An inner margin above the outer one leaves an empty ring.
        set_rings(4, 4095, 0);
        push_point(1100, 0, 0);
        push_point(100, 0, 0);

        // Widest ring: zero inner margin, largest outer margin.
        set_rings(4, 0, 4095);
        push_point(1, 0, 0);
        push_point(0, 0, 0);

        // Fill the whole table before any count above four is used, so no
        // entry is read before it has been written.
        for (int s = 0; s < crpf_pkg::CIRCLES; s++) push_circle(s);

        for (int p = 0; p < 9; p++) begin
            case (p)
                0: set_rings(64, 20, 200);
                1: set_rings(127, 0, 4095);     // count saturates at the table depth
                2: set_rings(1, 100, 300);
                3: set_rings(0, 500, 600);      // no circle consulted
                4: set_rings(16, 4095, 4095);   // equal margins, empty ring
                5: set_rings(40, 0, 0);
                default: begin
                    cnt = $urandom_range(1, 127);
                    a   = $urandom_range(0, 4095);
                    b   = $urandom_range(0, 4095);
                    // Mostly a proper ring, now and then an inverted one.
                    if (a > b && $urandom_range(0, 3) != 0) begin
                        r = a;
                        a = b;
                        b = r;
                    end
                    set_rings(cnt, a, b);
                end
            endcase
            no_gaps = (p == 2 || p == 6);
            n       = (ring_count > crpf_pkg::CIRCLES) ? crpf_pkg::CIRCLES
                                                       : int'(ring_count);
            items   = (p == 3) ? 60 : 140;
            for (int i = 0; i < items; i++) begin
                r = $urandom_range(0, 99);
                if (r < 15) push_circle($urandom_range(0, crpf_pkg::CIRCLES - 1));
                else if (r < 25) push_point($urandom, $urandom, $urandom);
                else if (r < 30) push_far_point(n);
                else push_aimed_point(n);
            end
        end

        wait_idle();

        $display("Run covered %0d point tests and %0d table loads under %0d ring settings.",
                 n_points, n_loads, n_settings);
        $display("Points kept: %0d, points dropped in a ring: %0d, mismatches: %0d.",
                 n_kept, n_dropped, err_count);
        if (err_count == 0) begin
            $display("PASS circle_ring_point_filter_top");
        end else begin
            $display("FAIL circle_ring_point_filter_top");
        end
        $finish;
    end

endmodule
